// ----- hdl/mccp_pkg.sv -----
// package for the minimum-cost column path unit
// types and constants shared by the top level and the testbench
package mccp_pkg;

  localparam int MAX_ROWS  = 128;
  localparam int MAX_COLS  = 256;
  localparam int MAX_REACH = 7;

  localparam int CELL_W = 24;
  localparam int OFF_W  = 5;
  localparam int SUM_W  = 32;

  localparam logic signed [CELL_W-1:0] CELL_MAX = 24'sh7FFFFF;
  localparam logic signed [CELL_W-1:0] CELL_MIN = 24'sh800000;
  localparam logic signed [CELL_W-1:0] INFINITY = 24'sh7FFFFF;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_TRACE = 1'b1;

  typedef enum logic [2:0] {
    REG_IMAGE_ROWS = 3'd0,
    REG_START_COL  = 3'd1,
    REG_END_COL    = 3'd2,
    REG_END_ROW    = 3'd3,
    REG_REACH      = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LREAD,
    ST_LSCAN,
    ST_LWRITE,
    ST_TREAD,
    ST_TOUT
  } state_t;

endpackage

// ----- hdl/min_cost_column_path_dp_unit.sv -----
// min_cost_column_path_dp_unit: top level, apb config, control fsm and stores
// depends on mccp_pkg and mccp_ram
//
// channel   direction  handshake
// in_       in         start high and busy low
// out_      out        out_valid, one cycle, no backpressure
// cfg_      in         apb write at psel & penable & pwrite
//
// a load pixel keeps busy high after its transfer while it reads each of the n
// neighbor rows inside the image (at most 2*reach+1), one memory read per neighbor,
// and then writes; in the first column it goes straight from the read state to the write
// a trace request keeps busy high through its read and result states and its result
// comes out registered after the result state; a refused one gives its result the next cycle
// and a load after completion is dropped, both without raising busy
// reset is synchronous, active low; stores are not cleared
// results cannot be stalled by the receiver
module min_cost_column_path_dp_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_mode,
  input  logic signed [15:0] in_gradient,
  output logic        out_valid,
  output logic [7:0]  out_path_col,
  output logic [6:0]  out_path_row,
  output logic signed [31:0] out_path_sum,
  output logic        out_last_step,
  output logic        out_bad_request,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int RW    = $clog2(mccp_pkg::MAX_ROWS);
  localparam int CW    = $clog2(mccp_pkg::MAX_COLS);
  localparam int AW    = RW + CW;
  localparam int DEPTH = mccp_pkg::MAX_ROWS * mccp_pkg::MAX_COLS;
  localparam int CELL_W = mccp_pkg::CELL_W;
  localparam int OFF_W  = mccp_pkg::OFF_W;

  // configuration
  logic [7:0] image_rows_r, start_col_r, end_col_r;
  logic [6:0] end_row_r;
  logic [2:0] reach_r;

  logic cfg_we;
  logic [2:0] cfg_idx;
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];

  always_comb begin
    case (mccp_pkg::reg_idx_t'(cfg_idx))
      mccp_pkg::REG_IMAGE_ROWS: prdata = {24'd0, image_rows_r};
      mccp_pkg::REG_START_COL:  prdata = {24'd0, start_col_r};
      mccp_pkg::REG_END_COL:    prdata = {24'd0, end_col_r};
      mccp_pkg::REG_END_ROW:    prdata = {25'd0, end_row_r};
      mccp_pkg::REG_REACH:      prdata = {29'd0, reach_r};
      default:                  prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_rows_r <= 8'd128;
      start_col_r  <= 8'd0;
      end_col_r    <= 8'd255;
      end_row_r    <= 7'd0;
      reach_r      <= 3'd1;
    end else if (cfg_we) begin
      case (mccp_pkg::reg_idx_t'(cfg_idx))
        mccp_pkg::REG_IMAGE_ROWS: image_rows_r <= pwdata[7:0];
        mccp_pkg::REG_START_COL:  start_col_r  <= pwdata[7:0];
        mccp_pkg::REG_END_COL:    end_col_r    <= pwdata[7:0];
        mccp_pkg::REG_END_ROW:    end_row_r    <= pwdata[6:0];
        mccp_pkg::REG_REACH:      reach_r      <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  logic cfg_hit;
  assign cfg_hit = cfg_we && (cfg_idx <= 3'd4);

  // effective configuration, kept 12 bits wide to cover MAX_ROWS
  logic [11:0] rows_eff, end_row_eff, reach_eff;
  logic [7:0]  end_col_eff;
  always_comb begin
    rows_eff = {4'd0, image_rows_r};
    if (rows_eff == 12'd0) rows_eff = 12'd1;
    if (rows_eff > 12'(mccp_pkg::MAX_ROWS)) rows_eff = 12'(mccp_pkg::MAX_ROWS);
    end_row_eff = ({5'd0, end_row_r} >= rows_eff) ? rows_eff - 12'd1 : {5'd0, end_row_r};
    reach_eff = ({9'd0, reach_r} > 12'(mccp_pkg::MAX_REACH)) ?
                12'(mccp_pkg::MAX_REACH) : {9'd0, reach_r};
    end_col_eff = (end_col_r < start_col_r) ? start_col_r : end_col_r;
  end

  // job state
  mccp_pkg::state_t state_r, state_nxt;
  logic [11:0] load_row_r, trace_row_r;
  logic [7:0]  load_col_r, trace_col_r;
  logic        load_done_r;
  logic signed [31:0] sum_r;
  logic signed [15:0] grad_r;
  logic [11:0] scan_r;         // neighbor row being read
  logic [11:0] scan_hi_r;
  logic        scan_pend_r;    // a read for a neighbor is in flight
  logic        scan_last_d_r;
  logic signed [4:0] cur_off_r;   // offset of the read in flight
  logic signed [CELL_W-1:0] best_r;
  logic signed [4:0] best_off_r;
  logic        found_r;

  logic accept;
  assign accept = start && !busy;
  assign busy   = (state_r != mccp_pkg::ST_IDLE);

  logic trace_ok;
  logic bad_req;
  assign trace_ok = load_done_r && (trace_col_r > start_col_r);
  assign bad_req  = accept && (in_mode == mccp_pkg::MODE_TRACE) && !trace_ok;

  logic first_col;
  assign first_col = (load_col_r == start_col_r);

  logic [11:0] lo_row;
  always_comb begin
    lo_row = (load_row_r > reach_eff) ? load_row_r - reach_eff : 12'd0;
  end

  // memory port
  logic            ram_we;
  logic [AW-1:0]   ram_addr;
  logic [CELL_W-1:0] cost_rd;
  logic [OFF_W-1:0]  off_rd;
  logic signed [CELL_W-1:0] cost_wr;
  logic [7:0] prev_col;
  assign prev_col = load_col_r - 8'd1;

  logic signed [25:0] csum;
  assign csum = 26'(best_r) + 26'(grad_r);
  always_comb begin
    if (csum > 26'(mccp_pkg::CELL_MAX)) cost_wr = mccp_pkg::CELL_MAX;
    else if (csum < 26'(mccp_pkg::CELL_MIN)) cost_wr = mccp_pkg::CELL_MIN;
    else cost_wr = csum[CELL_W-1:0];
  end

  always_comb begin
    ram_we   = 1'b0;
    ram_addr = {trace_col_r[CW-1:0], trace_row_r[RW-1:0]};
    case (state_r)
      mccp_pkg::ST_LSCAN: ram_addr = {prev_col[CW-1:0], scan_r[RW-1:0]};
      mccp_pkg::ST_LWRITE: begin
        ram_we   = 1'b1;
        ram_addr = {load_col_r[CW-1:0], load_row_r[RW-1:0]};
      end
      default: ;
    endcase
  end

  mccp_ram #(.WIDTH(CELL_W), .DEPTH(DEPTH)) u_cost_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr),
    .wdata(cost_wr), .rdata(cost_rd)
  );

  mccp_ram #(.WIDTH(OFF_W), .DEPTH(DEPTH)) u_off_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr),
    .wdata(best_off_r), .rdata(off_rd)
  );

  logic scan_last;
  assign scan_last = (scan_r >= scan_hi_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mccp_pkg::ST_IDLE:
        if (accept) begin
          if (in_mode == mccp_pkg::MODE_LOAD) begin
            state_nxt = load_done_r ? mccp_pkg::ST_IDLE : mccp_pkg::ST_LREAD;
          end else if (trace_ok) begin
            state_nxt = mccp_pkg::ST_TREAD;
          end
        end
      mccp_pkg::ST_LREAD:
        state_nxt = first_col ? mccp_pkg::ST_LWRITE : mccp_pkg::ST_LSCAN;
      mccp_pkg::ST_LSCAN:
        if (scan_pend_r && scan_last_d_r) state_nxt = mccp_pkg::ST_LWRITE;
      mccp_pkg::ST_LWRITE: state_nxt = mccp_pkg::ST_IDLE;
      mccp_pkg::ST_TREAD:  state_nxt = mccp_pkg::ST_TOUT;
      mccp_pkg::ST_TOUT:   state_nxt = mccp_pkg::ST_IDLE;
      default:             state_nxt = mccp_pkg::ST_IDLE;
    endcase
  end

  logic signed [CELL_W-1:0] cost_rd_s;
  assign cost_rd_s = cost_rd;

  // trace arithmetic
  logic signed [32:0] tsum;
  logic signed [31:0] tsum_sat;
  logic signed [12:0] nrow;
  logic [11:0] nrow_c;
  assign tsum = 33'(sum_r) + 33'(cost_rd_s);
  always_comb begin
    if (tsum > 33'sh07FFFFFFF) tsum_sat = 32'sh7FFFFFFF;
    else if (tsum < -33'sh080000000) tsum_sat = 32'sh80000000;
    else tsum_sat = tsum[31:0];
    nrow = $signed({1'b0, trace_row_r}) + 13'($signed(off_rd));
    if (nrow < 13'sd0) nrow_c = 12'd0;
    else if (nrow > $signed({1'b0, rows_eff - 12'd1})) nrow_c = rows_eff - 12'd1;
    else nrow_c = nrow[11:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= mccp_pkg::ST_IDLE;
      load_row_r    <= '0;
      load_col_r    <= 8'd0;
      load_done_r   <= 1'b0;
      trace_row_r   <= '0;
      trace_col_r   <= 8'd255;
      sum_r         <= '0;
      scan_pend_r   <= 1'b0;
      scan_last_d_r <= 1'b0;
      out_valid     <= 1'b0;
    end else if (cfg_hit) begin
      // restart the job; the trace start is loaded when the load completes
      state_r     <= mccp_pkg::ST_IDLE;
      out_valid   <= 1'b0;
      load_row_r  <= '0;
      load_done_r <= 1'b0;
      sum_r       <= '0;
      load_col_r  <= (cfg_idx == 3'(mccp_pkg::REG_START_COL)) ? pwdata[7:0] : start_col_r;
    end else begin
      state_r   <= state_nxt;
      out_valid <= bad_req || (state_r == mccp_pkg::ST_TOUT);
      case (state_r)
        mccp_pkg::ST_IDLE: begin
          if (bad_req) begin
            out_bad_request <= 1'b1;
            out_path_col    <= '0;
            out_path_row    <= '0;
            out_path_sum    <= '0;
            out_last_step   <= 1'b0;
          end
          if (accept) grad_r <= in_gradient;
        end
        mccp_pkg::ST_LREAD: begin
          scan_r      <= lo_row;
          scan_hi_r   <= (load_row_r + reach_eff > rows_eff - 12'd1) ?
                         rows_eff - 12'd1 : load_row_r + reach_eff;
          scan_pend_r <= 1'b0;
          found_r     <= first_col;
          best_r      <= '0;
          best_off_r  <= first_col ? 5'(-$signed({1'b0, load_row_r - lo_row})) : 5'sd0;
        end
        mccp_pkg::ST_LSCAN: begin
          // one read issued per cycle, data compared the cycle after
          scan_pend_r   <= !(scan_pend_r && scan_last_d_r);
          scan_last_d_r <= scan_last;
          cur_off_r     <= 5'($signed({1'b0, scan_r}) - $signed({1'b0, load_row_r}));
          if (!scan_last) scan_r <= scan_r + 12'd1;
          if (scan_pend_r && (!found_r || cost_rd_s < best_r)) begin
            best_r     <= cost_rd_s;
            best_off_r <= cur_off_r;
            found_r    <= 1'b1;
          end
        end
        mccp_pkg::ST_LWRITE: begin
          if (load_row_r + 12'd1 >= rows_eff) begin
            load_row_r <= '0;
            if (load_col_r >= end_col_eff) begin
              load_done_r <= 1'b1;
              trace_row_r <= end_row_eff;
              trace_col_r <= end_col_eff;
              sum_r       <= '0;
            end else begin
              load_col_r <= load_col_r + 8'd1;
            end
          end else begin
            load_row_r <= load_row_r + 12'd1;
          end
        end
        mccp_pkg::ST_TOUT: begin
          sum_r           <= tsum_sat;
          out_bad_request <= 1'b0;
          out_path_col    <= trace_col_r;
          out_path_row    <= trace_row_r[6:0];
          out_path_sum    <= tsum_sat;
          out_last_step   <= (trace_col_r == start_col_r + 8'd1);
          trace_row_r     <= nrow_c;
          trace_col_r     <= trace_col_r - 8'd1;
        end
        default: ;
      endcase
    end
  end

  // a result is never produced while a load is in progress
  a_no_out_in_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mccp_pkg::ST_LSCAN || state_r == mccp_pkg::ST_LWRITE) |-> !out_valid)
    else $error("result during load");
  // memory writes only happen before the load finishes
  a_write_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> !load_done_r)
    else $error("store write after load complete");
  // a good trace result follows its result state
  a_trace_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_bad_request) |-> $past(state_r) == mccp_pkg::ST_TOUT)
    else $error("trace result out of sequence");

endmodule

// ----- hdl/mccp_ram.sv -----
// generic single-port synchronous ram with registered read
// no dependencies
module mccp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- sim/testbench.sv -----
// testbench for min_cost_column_path_dp_unit: a scoreboard predicts every trace result
// from a local copy of the cost and offset stores, with random gaps, apb setup and many jobs
// depends on mccp_pkg (register indexes and modes) and the rtl under hdl/
`timescale 1ns / 1ps

module testbench;

  localparam int N_ROWS  = 128;
  localparam int N_COLS  = 256;
  localparam int N_REACH = 7;
  localparam int WATCHDOG_LIMIT = 3000;

  typedef struct packed {
    logic [7:0]         col;
    logic [6:0]         row;
    logic signed [31:0] total;
    logic               last;
    logic               bad;
  } path_entry_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_mode = 1'b0;
  logic signed [15:0] in_gradient = '0;
  logic out_valid;
  logic [7:0] out_path_col;
  logic [6:0] out_path_row;
  logic signed [31:0] out_path_sum;
  logic out_last_step;
  logic out_bad_request;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  min_cost_column_path_dp_unit u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_mode(in_mode), .in_gradient(in_gradient),
    .out_valid(out_valid), .out_path_col(out_path_col), .out_path_row(out_path_row),
    .out_path_sum(out_path_sum), .out_last_step(out_last_step),
    .out_bad_request(out_bad_request),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // local copy of the block's state
  logic signed [23:0] cost_mem [N_ROWS*N_COLS];
  logic signed [4:0]  offset_mem [N_ROWS*N_COLS];
  int rows_q = 128, start_q = 0, end_col_q = 255, end_row_q = 0, reach_q = 1;
  int load_row, load_col, trace_row, trace_col;
  bit load_done;
  logic signed [31:0] path_sum;

  path_entry_t path_q[$];
  int error_count = 0;
  int items_sent = 0;
  bit no_gaps = 0;

  function automatic int eff_rows();
    if (rows_q < 1) return 1;
    if (rows_q > N_ROWS) return N_ROWS;
    return rows_q;
  endfunction

  function automatic int eff_end_col();
    return (end_col_q < start_q) ? start_q : end_col_q;
  endfunction

  function automatic int eff_end_row();
    return (end_row_q >= eff_rows()) ? eff_rows() - 1 : end_row_q;
  endfunction

  function automatic int cell_idx(int row, int col);
    return (col % N_COLS) * N_ROWS + (row % N_ROWS);
  endfunction

  function automatic void restart_job();
    load_row = 0;
    load_col = start_q;
    load_done = 0;
    trace_row = eff_end_row();
    trace_col = eff_end_col();
    path_sum = 0;
  endfunction

  function automatic void predict_load(logic signed [15:0] g);
    int rows, r, best, best_off, nr, prv;
    bit found;
    longint c;
    rows = eff_rows();
    r = (reach_q > N_REACH) ? N_REACH : reach_q;
    best = 0;
    best_off = 0;
    found = 0;
    for (int off = -r; off <= r; off++) begin
      nr = load_row + off;
      if (nr < 0 || nr >= rows) continue;
      prv = (load_col == start_q) ? 0 : int'(cost_mem[cell_idx(nr, load_col - 1)]);
      if (!found || prv < best) begin
        best = prv;
        best_off = off;
        found = 1;
      end
    end
    c = longint'(best) + longint'(g);
    if (c > 64'sd8388607) c = 64'sd8388607;
    if (c < -64'sd8388608) c = -64'sd8388608;
    cost_mem[cell_idx(load_row, load_col)] = c[23:0];
    offset_mem[cell_idx(load_row, load_col)] = best_off[4:0];
    if (load_row + 1 >= rows) begin
      load_row = 0;
      if (load_col >= eff_end_col()) begin
        load_done = 1;
        trace_row = eff_end_row();
        trace_col = eff_end_col();
        path_sum = 0;
      end else begin
        load_col++;
      end
    end else begin
      load_row++;
    end
  endfunction

  function automatic path_entry_t predict_trace();
    path_entry_t e;
    longint s;
    int nr;
    e = '0;
    if (!load_done || trace_col <= start_q) begin
      e.bad = 1'b1;
      return e;
    end
    s = longint'(path_sum) + longint'(cost_mem[cell_idx(trace_row, trace_col)]);
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    if (s < -64'sd2147483648) s = -64'sd2147483648;
    path_sum = s[31:0];
    e.col = trace_col[7:0];
    e.row = trace_row[6:0];
    e.total = path_sum;
    e.last = (trace_col == start_q + 1);
    nr = trace_row + int'(offset_mem[cell_idx(trace_row, trace_col)]);
    if (nr < 0) nr = 0;
    if (nr > eff_rows() - 1) nr = eff_rows() - 1;
    trace_row = nr;
    trace_col--;
    return e;
  endfunction

  task automatic report_mismatch(string what, longint exp_v, longint got_v);
    $display("MISMATCH %s: expected %0d got %0d at %0t", what, exp_v, got_v, $time);
    error_count++;
  endtask

  // result checker
  always @(posedge clk) begin
    path_entry_t e;
    if (rst_n && out_valid) begin
      if (path_q.size() == 0) begin
        report_mismatch("unexpected result, col", -1, out_path_col);
      end else begin
        e = path_q.pop_front();
        if (out_path_col !== e.col) report_mismatch("path_col", e.col, out_path_col);
        if (out_path_row !== e.row) report_mismatch("path_row", e.row, out_path_row);
        if (out_path_sum !== e.total) report_mismatch("path_sum", e.total, out_path_sum);
        if (out_last_step !== e.last) report_mismatch("last_step", e.last, out_last_step);
        if (out_bad_request !== e.bad) report_mismatch("bad_request", e.bad, out_bad_request);
      end
    end
  end

  // watchdog: cycles with no transfer on any port
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (psel && penable && pwrite) || !rst_n)
      idle_cycles <= 0;
    else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  task automatic idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return;
    @(negedge clk);
    start <= 1'b0;
    if (r < 90) repeat ($urandom_range(0, 2)) @(negedge clk);
    else repeat ($urandom_range(10, 40)) @(negedge clk);
  endtask

  task automatic send_item(logic mode, logic signed [15:0] g);
    @(negedge clk);
    start <= 1'b1;
    in_mode <= mode;
    in_gradient <= g;
    while (busy) @(negedge clk);
    @(posedge clk);
    if (mode == mccp_pkg::MODE_TRACE) begin
      path_q.push_back(predict_trace());
      items_sent++;
    end else begin
      if (!load_done) items_sent++;
      if (!load_done) predict_load(g);
    end
    idle_gap();
  endtask

  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (path_q.size() != 0) @(negedge clk);
    while (busy) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(mccp_pkg::reg_idx_t idx, logic [31:0] value);
    drain_results();
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 5'(int'(idx) * 4);
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      mccp_pkg::REG_IMAGE_ROWS: rows_q = int'(value[7:0]);
      mccp_pkg::REG_START_COL:  start_q = int'(value[7:0]);
      mccp_pkg::REG_END_COL:    end_col_q = int'(value[7:0]);
      mccp_pkg::REG_END_ROW:    end_row_q = int'(value[6:0]);
      mccp_pkg::REG_REACH:      reach_q = int'(value[2:0]);
      default: ;
    endcase
    restart_job();
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic logic signed [15:0] pick_gradient();
    case ($urandom_range(0, 5))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'($signed($urandom_range(0, 64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  // one job: setup, load (maybe with a trace inside it and extra loads after), traces
  task automatic run_job(int rows, int sc, int ec, int er, int rch,
                         bit early, int extra, int spill);
    int n_loads, cut;
    write_reg(mccp_pkg::REG_IMAGE_ROWS, rows);
    write_reg(mccp_pkg::REG_START_COL, sc);
    write_reg(mccp_pkg::REG_END_COL, ec);
    write_reg(mccp_pkg::REG_END_ROW, er);
    write_reg(mccp_pkg::REG_REACH, rch);
    n_loads = eff_rows() * (eff_end_col() - start_q + 1);
    cut = early ? $urandom_range(0, n_loads - 1) : -1;
    for (int i = 0; i < n_loads; i++) begin
      if (i == cut) send_item(mccp_pkg::MODE_TRACE, 16'($urandom));
      send_item(mccp_pkg::MODE_LOAD, pick_gradient());
    end
    repeat (spill) send_item(mccp_pkg::MODE_LOAD, pick_gradient());
    for (int i = 0; i < eff_end_col() - start_q + extra; i++)
      send_item(mccp_pkg::MODE_TRACE, 16'($urandom));
  endtask

  task automatic test_early_trace();
    send_item(mccp_pkg::MODE_TRACE, 16'sh0000);
    send_item(mccp_pkg::MODE_LOAD, 16'sh1234);
    send_item(mccp_pkg::MODE_TRACE, 16'shFFFF);
  endtask

  task automatic test_extremes();
    no_gaps = 1;
    run_job(3, 5, 7, 2, 1, 0, 1, 0);
    no_gaps = 0;
    run_job(2, 0, 1, 0, 0, 1, 2, 2);
  endtask

  task automatic test_edge_config();
    run_job(0, 10, 12, 5, 7, 0, 1, 0);
    run_job(255, 20, 21, 127, 7, 0, 1, 0);
    run_job(4, 30, 25, 1, 1, 0, 2, 1);
    run_job(4, 250, 255, 100, 2, 0, 1, 0);
    run_job(128, 0, 1, 64, 3, 0, 1, 0);
  endtask

  task automatic test_restart_mid_load();
    write_reg(mccp_pkg::REG_IMAGE_ROWS, 5);
    write_reg(mccp_pkg::REG_START_COL, 40);
    write_reg(mccp_pkg::REG_END_COL, 43);
    repeat (7) send_item(mccp_pkg::MODE_LOAD, pick_gradient());
    run_job(5, 40, 43, 3, 2, 0, 1, 0);
  endtask

  task automatic test_random();
    int rows, sc, ec, r;
    while (items_sent < 1200) begin
      no_gaps = ($urandom_range(0, 5) == 0);
      r = $urandom_range(0, 19);
      if (r == 0) rows = 255;
      else if (r == 1) rows = 0;
      else rows = $urandom_range(1, 8);
      sc = $urandom_range(0, 255);
      ec = (rows > 8) ? sc + $urandom_range(0, 1) : sc + $urandom_range(0, 6);
      if (ec > 255) ec = 255;
      // end column at or below the start column
      if ($urandom_range(0, 9) == 0) ec = $urandom_range(0, sc);
      run_job(rows, sc, ec, $urandom_range(0, 127), $urandom_range(0, 7),
              ($urandom_range(0, 4) == 0), $urandom_range(0, 2), $urandom_range(0, 1));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    restart_job();
    test_early_trace();
    test_extremes();
    test_edge_config();
    test_restart_mid_load();
    test_random();
    drain_results();
    if (error_count == 0 && path_q.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
